@@ sv/lead_sublead_delta_phi_histogram_unit_defines.svh @@
// Assertion macros used by the checker of the delta phi histogram unit.
`ifndef LEAD_SUBLEAD_DELTA_PHI_HISTOGRAM_UNIT_DEFINES_SVH
`define LEAD_SUBLEAD_DELTA_PHI_HISTOGRAM_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define LSDP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define LSDP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/lsdp_pkg.sv @@
// Shared types and constants of the delta phi histogram unit.
package lsdp_pkg;

    localparam int NUM_BINS    = 125;
    localparam int COUNT_W     = 32;
    localparam int PT_W        = 16;
    localparam int PHI_W       = 16;
    localparam int BIN_W       = $clog2(NUM_BINS + 1);
    localparam int PROD_W      = PHI_W - 1 + BIN_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Half turn in phi units, held one bit wider than phi.
    localparam logic [PHI_W:0] PHI_PI     = (PHI_W + 1)'(1) << (PHI_W - 1);
    localparam logic [PHI_W:0] PHI_TWO_PI = (PHI_W + 1)'(1) << PHI_W;

    localparam logic [BIN_W-1:0]   OVF_BIN   = BIN_W'(NUM_BINS);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Operation codes of an input item.
    localparam logic OP_TRACK = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Kind codes of a result item.
    localparam logic KIND_FILL = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // One histogram command passed from the front to the back.
    typedef struct packed {
        logic             kind;
        logic [PHI_W-1:0] dphi;
        logic [BIN_W-1:0] bin;
    } cmd_t;

endpackage

@@ sv/lsdp_front.sv @@
// Front part: tracks leading and subleading pT, forms folded delta phi and its bin.
module lsdp_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         operation,
    input  logic [lsdp_pkg::PT_W-1:0]    pt,
    input  logic signed [lsdp_pkg::PHI_W-1:0] phi,
    input  logic                         last_track,
    input  logic [lsdp_pkg::BIN_W-1:0]   read_bin,
    output logic                         push,
    output lsdp_pkg::cmd_t               cmd
);

    logic [lsdp_pkg::PT_W-1:0]         lead_pt_reg, lead_pt_next;
    logic [lsdp_pkg::PT_W-1:0]         sub_pt_reg, sub_pt_next;
    logic signed [lsdp_pkg::PHI_W-1:0] lead_phi_reg, lead_phi_next;
    logic signed [lsdp_pkg::PHI_W-1:0] sub_phi_reg, sub_phi_next;

    logic [lsdp_pkg::PT_W-1:0]         upd_lead_pt, upd_sub_pt;
    logic signed [lsdp_pkg::PHI_W-1:0] upd_lead_phi, upd_sub_phi;
    logic signed [lsdp_pkg::PHI_W:0]   diff;
    logic [lsdp_pkg::PHI_W:0]          mag;
    logic [lsdp_pkg::PHI_W:0]          folded;
    logic [lsdp_pkg::PROD_W-1:0]       prod;
    logic [lsdp_pkg::BIN_W-1:0]        bin;
    logic                              is_track;

    assign is_track = accept && (operation == lsdp_pkg::OP_TRACK);

    // Leader and subleader after this track, with strict compares.
    always_comb
    begin
        upd_lead_pt  = lead_pt_reg;
        upd_lead_phi = lead_phi_reg;
        upd_sub_pt   = sub_pt_reg;
        upd_sub_phi  = sub_phi_reg;
        if (pt > lead_pt_reg)
        begin
            upd_sub_pt   = lead_pt_reg;
            upd_sub_phi  = lead_phi_reg;
            upd_lead_pt  = pt;
            upd_lead_phi = phi;
        end
        else if (pt > sub_pt_reg)
        begin
            upd_sub_pt  = pt;
            upd_sub_phi = phi;
        end
    end

    // Absolute difference, folded into the half turn, then binned.
    always_comb
    begin
        diff = {upd_lead_phi[lsdp_pkg::PHI_W-1], upd_lead_phi}
             - {upd_sub_phi[lsdp_pkg::PHI_W-1], upd_sub_phi};
        mag  = diff[lsdp_pkg::PHI_W] ? (lsdp_pkg::PHI_W + 1)'(-diff)
                                     : (lsdp_pkg::PHI_W + 1)'(diff);
        folded = (mag > lsdp_pkg::PHI_PI) ? (lsdp_pkg::PHI_TWO_PI - mag) : mag;
        prod = lsdp_pkg::PROD_W'(folded[lsdp_pkg::PHI_W-2:0])
             * lsdp_pkg::PROD_W'(lsdp_pkg::NUM_BINS);
        if (folded >= lsdp_pkg::PHI_PI)
        begin
            bin = lsdp_pkg::OVF_BIN;
        end
        else
        begin
            bin = prod[lsdp_pkg::PROD_W-1:lsdp_pkg::PHI_W-1];
        end
    end

    // Per-event state: updated on each track, cleared after the last one.
    always_comb
    begin
        lead_pt_next  = lead_pt_reg;
        lead_phi_next = lead_phi_reg;
        sub_pt_next   = sub_pt_reg;
        sub_phi_next  = sub_phi_reg;
        if (is_track)
        begin
            if (last_track)
            begin
                lead_pt_next  = '0;
                lead_phi_next = '0;
                sub_pt_next   = '0;
                sub_phi_next  = '0;
            end
            else
            begin
                lead_pt_next  = upd_lead_pt;
                lead_phi_next = upd_lead_phi;
                sub_pt_next   = upd_sub_pt;
                sub_phi_next  = upd_sub_phi;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_pt_reg  <= '0;
            lead_phi_reg <= '0;
            sub_pt_reg   <= '0;
            sub_phi_reg  <= '0;
        end
        else
        begin
            lead_pt_reg  <= lead_pt_next;
            lead_phi_reg <= lead_phi_next;
            sub_pt_reg   <= sub_pt_next;
            sub_phi_reg  <= sub_phi_next;
        end
    end

    // A read or the last track of an event makes one histogram command.
    always_comb
    begin
        push = accept && ((operation == lsdp_pkg::OP_READ) || last_track);
        if (operation == lsdp_pkg::OP_READ)
        begin
            cmd.kind = lsdp_pkg::KIND_READ;
            cmd.dphi = '0;
            cmd.bin  = read_bin;
        end
        else
        begin
            cmd.kind = lsdp_pkg::KIND_FILL;
            cmd.dphi = folded[lsdp_pkg::PHI_W-1:0];
            cmd.bin  = bin;
        end
    end

endmodule

@@ sv/lsdp_queue.sv @@
// Short command queue between the front and back parts.
module lsdp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lsdp_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output lsdp_pkg::cmd_t head_cmd
);

    lsdp_pkg::cmd_t                  entry_reg [lsdp_pkg::QUEUE_DEPTH];
    logic [lsdp_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [lsdp_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [lsdp_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign full      = (count_reg == lsdp_pkg::QCNT_W'(lsdp_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ sv/lsdp_back.sv @@
// Back part: histogram memory read-modify-write and the result register.
module lsdp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  lsdp_pkg::cmd_t                cmd,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          kind,
    output logic [lsdp_pkg::PHI_W-1:0]    delta_phi,
    output logic [lsdp_pkg::BIN_W-1:0]    bin_index,
    output logic [lsdp_pkg::COUNT_W-1:0]  bin_count
);

    logic [lsdp_pkg::COUNT_W-1:0] mem [0:lsdp_pkg::NUM_BINS];
    logic [lsdp_pkg::COUNT_W-1:0] rd_data_reg;
    logic [lsdp_pkg::NUM_BINS:0]  bin_vld_reg;

    logic                         s1_vld_reg;
    lsdp_pkg::cmd_t               s1_cmd_reg;
    logic                         s1_inrange_reg;

    logic                         last_wr_vld_reg;
    logic [lsdp_pkg::BIN_W-1:0]   last_wr_addr_reg;
    logic [lsdp_pkg::COUNT_W-1:0] last_wr_data_reg;

    logic                         out_vld_reg;
    logic                         out_kind_reg;
    logic [lsdp_pkg::PHI_W-1:0]   out_dphi_reg;
    logic [lsdp_pkg::BIN_W-1:0]   out_bin_reg;
    logic [lsdp_pkg::COUNT_W-1:0] out_count_reg;

    logic                         s1_adv;
    logic                         cmd_inrange;
    logic                         wr_en;
    logic [lsdp_pkg::COUNT_W-1:0] old_count;
    logic [lsdp_pkg::COUNT_W-1:0] new_count;

    assign s1_adv      = s1_vld_reg && (!out_vld_reg || out_ready);
    assign pop         = cmd_valid && (!s1_vld_reg || s1_adv);
    assign cmd_inrange = (cmd.bin <= lsdp_pkg::OVF_BIN);
    assign wr_en       = s1_adv && (s1_cmd_reg.kind == lsdp_pkg::KIND_FILL);

    // Current counter value: the latest write is forwarded because the memory
    // read for this command may have been taken in the same cycle as that write.
    always_comb
    begin
        if (!s1_inrange_reg)
        begin
            old_count = '0;
        end
        else if (last_wr_vld_reg && (last_wr_addr_reg == s1_cmd_reg.bin))
        begin
            old_count = last_wr_data_reg;
        end
        else if (bin_vld_reg[s1_cmd_reg.bin])
        begin
            old_count = rd_data_reg;
        end
        else
        begin
            old_count = '0;
        end
        new_count = (old_count == lsdp_pkg::COUNT_MAX) ? old_count : old_count + 1'b1;
    end

    // Histogram memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s1_cmd_reg.bin] <= new_count;
        end
        if (pop && cmd_inrange)
        begin
            rd_data_reg <= mem[cmd.bin];
        end
    end

    // Control of the memory stage, valid bits and write tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg      <= 1'b0;
            bin_vld_reg     <= '0;
            last_wr_vld_reg <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                s1_vld_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_vld_reg <= 1'b0;
            end
            if (wr_en)
            begin
                bin_vld_reg[s1_cmd_reg.bin] <= 1'b1;
                last_wr_vld_reg             <= 1'b1;
            end
            if (s1_adv)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the memory stage and the result.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_cmd_reg     <= cmd;
            s1_inrange_reg <= cmd_inrange;
        end
        if (wr_en)
        begin
            last_wr_addr_reg <= s1_cmd_reg.bin;
            last_wr_data_reg <= new_count;
        end
        if (s1_adv)
        begin
            out_kind_reg  <= s1_cmd_reg.kind;
            out_dphi_reg  <= s1_cmd_reg.dphi;
            out_bin_reg   <= s1_cmd_reg.bin;
            out_count_reg <= (s1_cmd_reg.kind == lsdp_pkg::KIND_FILL) ? new_count : old_count;
        end
    end

    assign out_valid = out_vld_reg;
    assign kind      = out_kind_reg;
    assign delta_phi = out_dphi_reg;
    assign bin_index = out_bin_reg;
    assign bin_count = out_count_reg;

endmodule

@@ sv/lead_sublead_delta_phi_histogram_unit.sv @@
// Top level of the leading/subleading track delta phi histogram unit.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------
//  input   | in_valid / in_ready  | operation, pt, phi, last_track, read_bin
//  output  | out_valid / out_ready| kind, delta_phi, bin_index, bin_count
//
// An item is taken every cycle while in_ready is high. Reads and last tracks of
// events give results via queue entry, memory read stage and result register,
// held while out_ready is low. The histogram memory reads one counter and
// writes one per cycle. Reset clears the per-event state and the per-bin valid
// bits at once, so no clearing pass is needed and the unit takes items right
// after reset. in_ready drops only when the four-entry command queue is full.
module lead_sublead_delta_phi_histogram_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  operation,
    input  logic [lsdp_pkg::PT_W-1:0]             pt,
    input  logic signed [lsdp_pkg::PHI_W-1:0]     phi,
    input  logic                                  last_track,
    input  logic [lsdp_pkg::BIN_W-1:0]            read_bin,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  kind,
    output logic [lsdp_pkg::PHI_W-1:0]            delta_phi,
    output logic [lsdp_pkg::BIN_W-1:0]            bin_index,
    output logic [lsdp_pkg::COUNT_W-1:0]          bin_count
);

    logic           accept;
    logic           push;
    logic           full;
    logic           pop;
    logic           not_empty;
    lsdp_pkg::cmd_t push_cmd;
    lsdp_pkg::cmd_t head_cmd;

    // An input transfer happens whenever in_valid is high and the queue has room.
    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    lsdp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .operation  (operation),
        .pt         (pt),
        .phi        (phi),
        .last_track (last_track),
        .read_bin   (read_bin),
        .push       (push),
        .cmd        (push_cmd)
    );

    lsdp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_cmd  (head_cmd)
    );

    lsdp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (not_empty),
        .cmd       (head_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .delta_phi (delta_phi),
        .bin_index (bin_index),
        .bin_count (bin_count)
    );

endmodule

@@ sv/lsdp_checker.sv @@
// Port-level checker of the delta phi histogram unit and its bind.
`include "lead_sublead_delta_phi_histogram_unit_defines.svh"

module lsdp_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic                                  operation,
    input logic [lsdp_pkg::PT_W-1:0]             pt,
    input logic signed [lsdp_pkg::PHI_W-1:0]     phi,
    input logic                                  last_track,
    input logic [lsdp_pkg::BIN_W-1:0]            read_bin,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic                                  kind,
    input logic [lsdp_pkg::PHI_W-1:0]            delta_phi,
    input logic [lsdp_pkg::BIN_W-1:0]            bin_index,
    input logic [lsdp_pkg::COUNT_W-1:0]          bin_count
);

    // A stalled result keeps its valid and its count.
    `LSDP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(bin_count), "stalled result changed")

    // A read result carries no phi difference.
    `LSDP_ASSERT_IMP(a_read_dphi, out_valid && (kind == lsdp_pkg::KIND_READ), delta_phi == '0, "read result with nonzero delta phi")

    // A fill always leaves its counter at one or more.
    `LSDP_ASSERT_IMP(a_fill_count, out_valid && (kind == lsdp_pkg::KIND_FILL), bin_count != '0, "fill result with zero count")

    // The overflow bin is filled exactly when the difference is a half turn.
    `LSDP_ASSERT_IMP(a_fill_ovf, out_valid && (kind == lsdp_pkg::KIND_FILL), (bin_index == lsdp_pkg::OVF_BIN) == (delta_phi == lsdp_pkg::PHI_W'(lsdp_pkg::PHI_PI)), "overflow bin and delta phi disagree")

endmodule

bind lead_sublead_delta_phi_histogram_unit lsdp_checker u_lsdp_checker (.*);
